FILE: design/assert_macros.svh
// Assertion macros shared by the remap RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PLR_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define PLR_ASSERT(lbl, prop)
`define PLR_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

FILE: design/plr_pkg.sv
// Shared types and register indexes for the piecewise linear pixel remap.
// No dependencies.
package plr_pkg;

  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned NUM_SEG_REGS = 6;
  localparam int unsigned FIELD_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG5 = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL = 8'd7;

  localparam logic [47:0] CLIP_RESET = 48'h0000_FFFF_0000;

  // one segment register, packed as written over the config port
  typedef struct packed {
    logic [FIELD_W-1:0] out_max;
    logic [FIELD_W-1:0] out_min;
    logic [FIELD_W-1:0] in_max;
    logic [FIELD_W-1:0] in_min;
  } seg_cfg_t;

endpackage

FILE: design/plr_seg.sv
// One remap segment: range check, multiply, pipelined restoring divide, offset.
// Depends on plr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module plr_seg #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [PIXEL_BITS+FRAC_BITS-1:0] v_i,
  input  plr_pkg::seg_cfg_t              cfg_i,
  input  logic                           active_i,
  output logic                           valid_o,
  output logic [PIXEL_BITS+FRAC_BITS-1:0] v_o
);

  localparam int unsigned P   = PIXEL_BITS;
  localparam int unsigned VW  = PIXEL_BITS + FRAC_BITS;
  localparam int unsigned NW  = VW + P;
  localparam int unsigned LAT = VW + 3;

  // stage A: range check and operand prep
  logic [P-1:0]  imin, imax, omin, omax;
  logic [VW-1:0] fmin, fmax;
  logic          a_neg;

  assign imin  = cfg_i.in_min[P-1:0];
  assign imax  = cfg_i.in_max[P-1:0];
  assign omin  = cfg_i.out_min[P-1:0];
  assign omax  = cfg_i.out_max[P-1:0];
  assign fmin  = VW'(imin) << FRAC_BITS;
  assign fmax  = VW'(imax) << FRAC_BITS;
  assign a_neg = omax < omin;

  logic          a_valid_q, a_inside_q, a_zero_q, a_neg_q;
  logic [VW-1:0] a_v_q, a_d_q;
  logic [P-1:0]  a_span_q, a_mag_q, a_omin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_inside_q <= active_i && (v_i >= fmin) && (v_i <= fmax);
    a_zero_q   <= imin == imax;
    a_neg_q    <= a_neg;
    a_v_q      <= v_i;
    a_d_q      <= v_i - fmin;
    a_span_q   <= imax - imin;
    a_mag_q    <= a_neg ? (omin - omax) : (omax - omin);
    a_omin_q   <= omin;
  end

  // stage B: magnitude product
  logic          b_valid_q, b_inside_q, b_zero_q, b_neg_q;
  logic [VW-1:0] b_v_q;
  logic [P-1:0]  b_span_q, b_omin_q;
  logic [NW-1:0] b_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_inside_q <= a_inside_q;
    b_zero_q   <= a_zero_q;
    b_neg_q    <= a_neg_q;
    b_v_q      <= a_v_q;
    b_span_q   <= a_span_q;
    b_omin_q   <= a_omin_q;
    b_prod_q   <= NW'(a_d_q) * NW'(a_mag_q);
  end

  // divide stages: one quotient bit per stage, quotient shifts into num
  logic          dv_valid  [0:VW];
  logic          dv_inside [0:VW];
  logic          dv_zero   [0:VW];
  logic          dv_neg    [0:VW];
  logic [VW-1:0] dv_v      [0:VW];
  logic [P-1:0]  dv_span   [0:VW];
  logic [P-1:0]  dv_omin   [0:VW];
  logic [P-1:0]  dv_rem    [0:VW];
  logic [VW-1:0] dv_num    [0:VW];

  // quotient fits in VW bits, so the top P bits start below the span
  assign dv_valid[0]  = b_valid_q;
  assign dv_inside[0] = b_inside_q;
  assign dv_zero[0]   = b_zero_q;
  assign dv_neg[0]    = b_neg_q;
  assign dv_v[0]      = b_v_q;
  assign dv_span[0]   = b_span_q;
  assign dv_omin[0]   = b_omin_q;
  assign dv_rem[0]    = b_prod_q[NW-1:VW];
  assign dv_num[0]    = b_prod_q[VW-1:0];

  for (genvar k = 0; k < VW; k++) begin : g_div
    logic [P:0] trial, diff;
    logic       ge;

    assign trial = {dv_rem[k], dv_num[k][VW-1]};
    assign ge    = trial >= {1'b0, dv_span[k]};
    assign diff  = trial - {1'b0, dv_span[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_inside[k+1] <= dv_inside[k];
      dv_zero[k+1]   <= dv_zero[k];
      dv_neg[k+1]    <= dv_neg[k];
      dv_v[k+1]      <= dv_v[k];
      dv_span[k+1]   <= dv_span[k];
      dv_omin[k+1]   <= dv_omin[k];
      dv_rem[k+1]    <= ge ? diff[P-1:0] : trial[P-1:0];
      dv_num[k+1]    <= {dv_num[k][VW-2:0], ge};
    end
  end

  // final stage: add or subtract the quotient from out_min
  logic [VW-1:0] omin_f;
  logic [VW:0]   sum;
  logic [VW-1:0] v_d;
  logic          valid_q;
  logic [VW-1:0] v_q;

  assign omin_f = VW'(dv_omin[VW]) << FRAC_BITS;
  assign sum    = dv_neg[VW] ? ({1'b0, omin_f} - {1'b0, dv_num[VW]})
                             : ({1'b0, omin_f} + {1'b0, dv_num[VW]});

  always_comb begin
    if (!dv_inside[VW]) begin
      v_d = dv_v[VW];
    end else if (dv_zero[VW]) begin
      v_d = omin_f;
    end else begin
      v_d = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid[VW];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign valid_o = valid_q;
  assign v_o     = v_q;

  `PLR_ASSERT(a_seg_latency, valid_o |-> $past(valid_i, LAT))
  `PLR_ASSERT(a_div_rem_bound,
    (dv_valid[VW] && dv_inside[VW] && !dv_zero[VW]) |-> (dv_rem[VW] < dv_span[VW]))
  `PLR_ASSERT_MSG(a_rescale_range,
    (dv_valid[VW] && dv_inside[VW] && !dv_zero[VW]) |-> (sum[VW] == 1'b0),
    "rescaled value left the output range")

endmodule

FILE: design/piecewise_linear_pixel_remap.sv
// Top level of the piecewise linear pixel remap: config registers, input
// stage, segment chain and round/clip output stage. Depends on plr_pkg, plr_seg.
//
// Usage:
//  - Pixel requests: drive pixel_in_i and pulse start; a request is taken at
//    every rising edge with start high and busy low. busy is always low, so a
//    new pixel can enter every cycle.
//  - Results: pixel_out_o is shown for one cycle with result_valid_o high.
//    The receiver cannot stall; results come out in request order.
//  - Pipeline: each segment is a range check, a multiply, a restoring divider
//    that makes one quotient bit per stage, and an offset add; the divider
//    depth sets the pipeline length. Throughput is one pixel per cycle.
//  - Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i. Indexes
//    0..5 are segments, 6 is clip limits, 7 is control; others are dropped.
//    Write only while no pixel is in flight.
//  - Reset: config returns to its reset values, all pipeline valids clear.
//  - Segments beyond the active count, inverted input ranges and pixels
//    outside a range leave the value untouched; the null pixel and the
//    disabled mode bypass the chain through a matching delay line.
module piecewise_linear_pixel_remap #(
  parameter int unsigned PIXEL_BITS   = 16,
  parameter int unsigned NUM_SEGMENTS = 6,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel request
  input  logic                             start,
  output logic                             busy,
  input  logic [15:0]                      pixel_in_i,
  // result
  output logic                             result_valid_o,
  output logic [15:0]                      pixel_out_o,
  // config writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [plr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned P       = PIXEL_BITS;
  localparam int unsigned VW      = PIXEL_BITS + FRAC_BITS;
  localparam int unsigned SEG_LAT = VW + 3;
  localparam int unsigned CHAIN   = NUM_SEGMENTS * SEG_LAT;
  localparam int unsigned HALF    = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;
  localparam logic [2:0]  NSEG3   = 3'(NUM_SEGMENTS);

  // ---------------------------------------------------------------- config
  logic [plr_pkg::CFG_DATA_W-1:0] seg_q [plr_pkg::NUM_SEG_REGS];
  logic [47:0]                    clip_q;
  logic [3:0]                     ctrl_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < plr_pkg::NUM_SEG_REGS; i++) begin
        seg_q[i] <= '0;
      end
      clip_q <= plr_pkg::CLIP_RESET;
      ctrl_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i) inside
        [plr_pkg::CFG_SEG0:plr_pkg::CFG_SEG5]: seg_q[cfg_index_i[2:0]] <= cfg_data_i;
        plr_pkg::CFG_CLIP:                     clip_q <= cfg_data_i[47:0];
        plr_pkg::CFG_CTRL:                     ctrl_q <= cfg_data_i[3:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  logic [P-1:0] cmin, cmax, nullv;
  logic [2:0]   cnt;
  logic         enable;

  assign cmin   = clip_q[P-1:0];
  assign cmax   = clip_q[16+P-1:16];
  assign nullv  = clip_q[32+P-1:32];
  assign enable = ctrl_q[3];
  assign cnt    = (ctrl_q[2:0] > NSEG3) ? NSEG3 : ctrl_q[2:0];

  // ----------------------------------------------------------- input stage
  logic         in_valid_q;
  logic [P-1:0] in_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_pix_q <= pixel_in_i[P-1:0];
  end

  // disabled passes the pixel; a null pixel passes the null value (same bits)
  logic byp_flag;
  assign byp_flag = !enable || (in_pix_q == nullv);

  // --------------------------------------------------------- segment chain
  logic          ch_valid [0:NUM_SEGMENTS];
  logic [VW-1:0] ch_v     [0:NUM_SEGMENTS];

  assign ch_valid[0] = in_valid_q;
  assign ch_v[0]     = VW'(in_pix_q) << FRAC_BITS;

  for (genvar s = 0; s < NUM_SEGMENTS; s++) begin : g_seg
    plr_seg #(
      .PIXEL_BITS(PIXEL_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_seg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[s]),
      .v_i     (ch_v[s]),
      .cfg_i   (plr_pkg::seg_cfg_t'(seg_q[s])),
      .active_i(3'(s) < cnt),
      .valid_o (ch_valid[s+1]),
      .v_o     (ch_v[s+1])
    );
  end

  // bypass delay line, aligned with the chain output
  logic         byp_flag_q [0:CHAIN-1];
  logic [P-1:0] byp_val_q  [0:CHAIN-1];

  always_ff @(posedge clk_i) begin
    byp_flag_q[0] <= byp_flag;
    byp_val_q[0]  <= in_pix_q;
    for (int i = 1; i < CHAIN; i++) begin
      byp_flag_q[i] <= byp_flag_q[i-1];
      byp_val_q[i]  <= byp_val_q[i-1];
    end
  end

  // ------------------------------------------------- round, clip and output
  logic [VW:0]  rnd;
  logic [P-1:0] rval, clipped, out_d;

  assign rnd  = ({1'b0, ch_v[NUM_SEGMENTS]} + (VW+1)'(HALF)) >> FRAC_BITS;
  assign rval = rnd[P-1:0];

  always_comb begin
    if (rval < cmin) begin
      clipped = cmin;
    end else if (rval > cmax) begin
      clipped = cmax;
    end else begin
      clipped = rval;
    end
    out_d = byp_flag_q[CHAIN-1] ? byp_val_q[CHAIN-1] : clipped;
  end

  logic         out_valid_q;
  logic [P-1:0] out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ch_valid[NUM_SEGMENTS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign pixel_out_o    = 16'(out_pix_q);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for piecewise_linear_pixel_remap.
// Predicts each remapped pixel and compares it with the block's output.
// Depends on plr_pkg and the piecewise_linear_pixel_remap RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 164;
  localparam int MAX_CYCLES = 400000;
  localparam int FRAC      = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] pixel_in_i = '0;
  logic        result_valid_o;
  logic [15:0] pixel_out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [plr_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [plr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // our copy of the register file
  plr_pkg::seg_cfg_t seg_shadow [6];
  logic [47:0]       clip_shadow;
  logic [3:0]        ctrl_shadow;

  logic [15:0] expected_pixels [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;

  piecewise_linear_pixel_remap uut (.*);

  always #10 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    error_count++;
  endtask

  // remap prediction: signed fixed point s55.8, truncating division
  function automatic logic [15:0] remap_pixel(input logic [15:0] pix);
    logic signed [63:0] v, r, imin, imax, omin, omax, span;
    int unsigned cnt;
    logic [15:0] cmin, cmax, nullv;
    cmin = clip_shadow[15:0];
    cmax = clip_shadow[31:16];
    nullv = clip_shadow[47:32];
    if (!ctrl_shadow[3]) return pix;
    if (pix == nullv) return nullv;
    cnt = ctrl_shadow[2:0];
    if (cnt > 6) cnt = 6;
    v = 64'(pix) <<< FRAC;
    for (int s = 0; s < cnt; s++) begin
      imin = 64'(seg_shadow[s].in_min);
      imax = 64'(seg_shadow[s].in_max);
      omin = 64'(seg_shadow[s].out_min);
      omax = 64'(seg_shadow[s].out_max);
      if (v >= (imin <<< FRAC) && v <= (imax <<< FRAC)) begin
        span = imax - imin;
        if (span <= 0) v = omin <<< FRAC;
        else v = ((v - (imin <<< FRAC)) * (omax - omin)) / span + (omin <<< FRAC);
      end
    end
    if (v >= 0) r = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    else r = -((-v + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    if (r < 64'(cmin)) r = 64'(cmin);
    else if (r > 64'(cmax)) r = 64'(cmax);
    return r[15:0];
  endfunction

  // result checker: receiver never stalls, so every strobe is taken
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", pixel_out_o));
      end else begin
        logic [15:0] want;
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_out_o !== want)
          report_mismatch($sformatf("pixel_out got %h want %h", pixel_out_o, want));
      end
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int gap_cycles();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    return n;
  endfunction

  // one pixel request, held until taken
  task automatic send_pixel(input logic [15:0] pix);
    int n;
    pixel_in_i <= pix;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    expected_pixels = {expected_pixels, remap_pixel(pix)};
    pixels_sent++;
    @(negedge clk_i);
    if ($urandom_range(0, 2) == 0) begin
      n = gap_cycles();
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(input logic [plr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= plr_pkg::CFG_SEG5) seg_shadow[idx] = data;
    else if (idx == plr_pkg::CFG_CLIP) clip_shadow = data[47:0];
    else if (idx == plr_pkg::CFG_CTRL) ctrl_shadow = data[3:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_seg();
    logic [15:0] a, b;
    a = 16'($urandom); b = 16'($urandom);
    if ($urandom_range(0, 3) != 0 && a > b) {a, b} = {b, a};
    return {16'($urandom), 16'($urandom), b, a};
  endfunction

  // pass-through: enable off, null check included
  task automatic test_disabled();
    write_reg(plr_pkg::CFG_CTRL, 64'h7);
    foreach (seg_shadow[i]) write_reg(plr_pkg::CFG_SEG0 + 8'(i), rand_seg());
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(clip_shadow[47:32]);
    send_pixel(16'h5AA5);
    drain();
  endtask

  // directed corners: identity clip, zero span, inverted range, null, full scale
  task automatic test_directed();
    write_reg(plr_pkg::CFG_CLIP, 64'({16'h1234, 16'hFFFF, 16'h0000}));
    write_reg(plr_pkg::CFG_SEG0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}); // identity
    write_reg(plr_pkg::CFG_SEG0 + 8'd1,
              {16'h0100, 16'h0200, 16'h0800, 16'h0800}); // zero span
    write_reg(plr_pkg::CFG_SEG0 + 8'd2,
              {16'hFFFF, 16'h0000, 16'h0010, 16'h9000}); // inverted
    write_reg(plr_pkg::CFG_SEG0 + 8'd3,
              {16'h0000, 16'hFFFF, 16'h8000, 16'h4000}); // falling
    write_reg(plr_pkg::CFG_SEG0 + 8'd4,
              {16'h0003, 16'h0000, 16'h0007, 16'h0000}); // rounding
    write_reg(plr_pkg::CFG_SEG0 + 8'd5, {16'h0000, 16'h0000, 16'hFFFF, 16'h0000});
    write_reg(plr_pkg::CFG_CTRL, 64'hF); // count 7 saturates
    send_pixel(16'h0000); send_pixel(16'hFFFF); send_pixel(16'h1234);
    send_pixel(16'h0800); send_pixel(16'h4000); send_pixel(16'h8000);
    send_pixel(16'h0001); send_pixel(16'h0005);
    drain();
    write_reg(plr_pkg::CFG_CTRL, 64'h8); // enabled, no segments
    write_reg(plr_pkg::CFG_CLIP, 64'({16'hFFFF, 16'h0100, 16'h0200})); // inverted clip
    send_pixel(16'h0000); send_pixel(16'h0150); send_pixel(16'h0300);
    send_pixel(16'hFFFF);
    drain();
    write_reg(plr_pkg::CFG_CTRL, 64'hB);
    write_reg(plr_pkg::CFG_CLIP, 64'({16'h0000, 16'hFFFF, 16'h0000}));
    send_pixel(16'h0000); send_pixel(16'h7FFF); send_pixel(16'hFFFF);
    drain();
  endtask

  // random segment sets and pixels, several settings
  task automatic test_random();
    for (int phase = 0; phase < 13; phase++) begin
      foreach (seg_shadow[i]) write_reg(plr_pkg::CFG_SEG0 + 8'(i), rand_seg());
      write_reg(plr_pkg::CFG_CLIP, ($urandom_range(0, 2) == 0) ?
                64'({16'($urandom), 16'($urandom), 16'($urandom)}) :
                64'({16'($urandom), 16'hFFFF, 16'h0000}));
      write_reg(plr_pkg::CFG_CTRL, (phase == 0) ? 64'h0 : 64'($urandom_range(8, 15)));
      // one stray index that must be dropped
      write_reg(8'(8 + $urandom_range(0, 247)), {$urandom, $urandom});
      for (int n = 0; n < 50; n++) begin
        logic [15:0] p;
        case ($urandom_range(0, 5))
          0: p = clip_shadow[47:32];
          1: p = seg_shadow[$urandom_range(0, 5)].in_min + 16'($urandom_range(0, 2));
          2: p = seg_shadow[$urandom_range(0, 5)].in_max - 16'($urandom_range(0, 2));
          default: p = 16'($urandom);
        endcase
        send_pixel(p);
      end
      drain();
    end
  endtask

  initial begin
    foreach (seg_shadow[i]) seg_shadow[i] = '0;
    clip_shadow = plr_pkg::CLIP_RESET;
    ctrl_shadow = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_disabled();
    test_directed();
    test_random();
    $display("sent %0d pixels, checked %0d results over 17 register settings",
             pixels_sent, pixels_checked);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_pixels.size());
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/plr_pkg.sv
design/plr_seg.sv
design/piecewise_linear_pixel_remap.sv
verif/tb.sv
